// ===== hdl/pfn_pkg.sv =====
package pfn_pkg;

    // default sizes
    localparam int MAX_PREFIX_DEF = 16;
    localparam int MAX_LINE_DEF   = 128;

    localparam logic [7:0] NEWLINE_BYTE = 8'h0A;

    // input opcodes
    localparam logic OP_LINE_BYTE = 1'b0;
    localparam logic OP_REPORT    = 1'b1;

    // report verdicts
    localparam logic [1:0] VERDICT_NONE   = 2'd0;
    localparam logic [1:0] VERDICT_SINGLE = 2'd1;
    localparam logic [1:0] VERDICT_SET    = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_PREFIX_LOW  = 2'd0;
    localparam logic [1:0] CFG_PREFIX_HIGH = 2'd1;
    localparam logic [1:0] CFG_PREFIX_LEN  = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic byte_take;    // line byte transfer taken
        logic rd_start;     // report read taken, load scan start from pointer
        logic restart_zero; // first search wrapped, search again from zero
        logic next_start;   // keep found byte, search for its successor
        logic next_latch;   // keep successor search result
        logic scan_step;    // move scan to the next set word
        logic emit;         // load output register, advance pointer
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic [1:0] mode;
        logic       scan_hit;
        logic       scan_miss;
        logic       out_free;
    } t_stat;

    function automatic logic [7:0] fold_lower(input logic [7:0] c);
        fold_lower = (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
    endfunction

    function automatic logic [7:0] fold_upper(input logic [7:0] c);
        fold_upper = (c >= 8'h61 && c <= 8'h7A) ? c - 8'h20 : c;
    endfunction

endpackage

// ===== hdl/pfn_ctrl.sv =====
module pfn_ctrl import pfn_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_opcode,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_FIND = 4'b0010,
        ST_NEXT = 4'b0100,
        ST_EMIT = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign o_in_ready = (r_state == ST_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_opcode == OP_LINE_BYTE) begin
                        o_cmd.byte_take = 1'b1;
                    end else begin
                        o_cmd.rd_start = 1'b1;
                        n_state = (i_stat.mode == VERDICT_SET) ? ST_FIND : ST_EMIT;
                    end
                end
            end
            ST_FIND: begin
                if (i_stat.scan_hit) begin
                    o_cmd.next_start = 1'b1;
                    n_state = ST_NEXT;
                end else if (i_stat.scan_miss) begin
                    o_cmd.restart_zero = 1'b1;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            ST_NEXT: begin
                if (i_stat.scan_hit || i_stat.scan_miss) begin
                    o_cmd.next_latch = 1'b1;
                    n_state = ST_EMIT;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            ST_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== hdl/pfn_dpath.sv =====
module pfn_dpath import pfn_pkg::*; #(
    parameter int MAX_PREFIX = MAX_PREFIX_DEF,
    parameter int MAX_LINE   = MAX_LINE_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  logic [7:0]  i_char,
    input  logic        i_line_end,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_verdict,
    output logic [7:0]  o_char,
    output logic        o_last
);

    localparam int         ADDR_W     = $clog2(MAX_LINE);
    localparam logic [8:0] STORE_CAP  = 9'((MAX_LINE < 255) ? MAX_LINE : 255);
    localparam logic [4:0] PREFIX_MAX = 5'(MAX_PREFIX);

    // configuration
    logic [63:0] r_prefix_low;
    logic [63:0] r_prefix_high;
    logic [4:0]  r_prefix_len;

    // line state
    logic [7:0]  r_pos;
    logic        r_match;
    logic        r_ended;
    logic [1:0]  r_count;
    logic [63:0] r_set [4];
    logic        r_set_any;
    logic [7:0]  r_flen;
    logic        r_capturing;
    logic [7:0]  r_ptr;

    // first line store
    logic [7:0]  r_store [MAX_LINE];
    logic [7:0]  r_rdata;

    // scan unit
    logic [2:0]  r_scan_word;
    logic [5:0]  r_scan_lo;
    logic [7:0]  r_found;
    logic [7:0]  r_nxt;
    logic        r_nxt_hit;

    logic [4:0]   plen;
    logic [127:0] prefix_all;
    logic [7:0]   prefix_byte;
    logic [7:0]   byte_c;
    logic         is_nl;
    logic         take;
    logic         lt_plen;
    logic         eq_plen;
    logic         n_match;
    logic [7:0]   n_pos;
    logic         set_ins;
    logic         store_we;
    logic         line_hit;
    logic [8:0]   len_ext;

    logic [63:0]  scan_bits;
    logic [63:0]  masked;
    logic [5:0]   low_idx;
    logic         scan_hit;
    logic [7:0]   hit_pos;
    logic [8:0]   succ_start;

    logic [1:0]   mode;
    logic [8:0]   ptr_inc;
    logic         single_last;
    logic [1:0]   n_verdict;
    logic [7:0]   n_char;
    logic         n_last;
    logic [7:0]   n_ptr;

    // ---- line byte path ----
    assign plen        = (r_prefix_len > PREFIX_MAX) ? PREFIX_MAX : r_prefix_len;
    assign prefix_all  = {r_prefix_high, r_prefix_low};
    assign prefix_byte = fold_lower(prefix_all[{r_pos[3:0], 3'b000} +: 8]);
    assign byte_c      = fold_lower(i_char);
    assign is_nl       = (i_char == NEWLINE_BYTE);
    assign take        = i_cmd.byte_take && !r_ended && !is_nl;
    assign lt_plen     = ({1'b0, r_pos} < {4'b0000, plen});
    assign eq_plen     = ({1'b0, r_pos} == {4'b0000, plen});
    assign n_match     = r_match && !(take && lt_plen && (byte_c != prefix_byte));
    assign set_ins     = take && eq_plen && r_match;
    assign store_we    = take && r_capturing && ({1'b0, r_pos} < STORE_CAP);
    assign n_pos       = (take && r_pos != 8'hFF) ? r_pos + 8'd1 : r_pos;
    assign len_ext     = {1'b0, n_pos};
    assign line_hit    = i_line_end && n_match && (len_ext >= {4'b0000, plen});

    // ---- set scan, one 64-bit word per cycle ----
    assign scan_bits = r_set[r_scan_word[1:0]];
    assign masked    = scan_bits & ({64{1'b1}} << r_scan_lo);

    always_comb begin
        low_idx = '0;
        for (int i = 63; i >= 0; i--) begin
            if (masked[i]) begin
                low_idx = 6'(i);
            end
        end
    end

    assign scan_hit   = (|masked) && !r_scan_word[2];
    assign hit_pos    = {r_scan_word[1:0], low_idx};
    assign succ_start = {1'b0, hit_pos} + 9'd1;

    // ---- report selection ----
    always_comb begin
        if (r_count == 2'd1) begin
            mode = VERDICT_SINGLE;
        end else if (r_count == 2'd2 && r_set_any) begin
            mode = VERDICT_SET;
        end else begin
            mode = VERDICT_NONE;
        end
    end

    assign ptr_inc     = {1'b0, r_ptr} + 9'd1;
    assign single_last = (r_flen == 8'd0) || (ptr_inc >= {1'b0, r_flen});

    always_comb begin
        case (mode)
            VERDICT_SINGLE: begin
                n_verdict = VERDICT_SINGLE;
                n_char    = (r_flen == 8'd0) ? 8'd0 : fold_upper(r_rdata);
                n_last    = single_last;
                n_ptr     = single_last ? 8'd0 : ptr_inc[7:0];
            end
            VERDICT_SET: begin
                n_verdict = VERDICT_SET;
                n_char    = fold_upper(r_found);
                n_last    = !r_nxt_hit;
                n_ptr     = r_nxt_hit ? r_nxt : 8'd0;
            end
            default: begin
                n_verdict = VERDICT_NONE;
                n_char    = 8'd0;
                n_last    = 1'b1;
                n_ptr     = 8'd0;
            end
        endcase
    end

    assign o_stat.mode      = mode;
    assign o_stat.scan_hit  = scan_hit;
    assign o_stat.scan_miss = !scan_hit && (r_scan_word[2] || r_scan_word[1:0] == 2'd3);
    assign o_stat.out_free  = !o_out_valid || i_out_ready;

    // ---- control state ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prefix_low  <= '0;
            r_prefix_high <= '0;
            r_prefix_len  <= '0;
            r_pos         <= '0;
            r_match       <= 1'b1;
            r_ended       <= 1'b0;
            r_count       <= '0;
            for (int w = 0; w < 4; w++) begin
                r_set[w] <= '0;
            end
            r_set_any     <= 1'b0;
            r_flen        <= '0;
            r_capturing   <= 1'b1;
            r_ptr         <= '0;
            r_scan_word   <= '0;
            r_scan_lo     <= '0;
            r_nxt_hit     <= 1'b0;
            o_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_PREFIX_LOW:  r_prefix_low  <= i_cfg_data;
                    CFG_PREFIX_HIGH: r_prefix_high <= i_cfg_data;
                    CFG_PREFIX_LEN:  r_prefix_len  <= i_cfg_data[4:0];
                    default: ;
                endcase
            end

            if (i_cmd.byte_take) begin
                r_ptr <= '0;
                if (set_ins) begin
                    r_set[byte_c[7:6]][byte_c[5:0]] <= 1'b1;
                    r_set_any <= 1'b1;
                end
                if (i_line_end) begin
                    r_pos   <= '0;
                    r_match <= 1'b1;
                    r_ended <= 1'b0;
                    if (line_hit) begin
                        if (r_count == 2'd0 && r_capturing) begin
                            r_flen      <= (len_ext < STORE_CAP) ? n_pos : STORE_CAP[7:0];
                            r_capturing <= 1'b0;
                        end
                        if (r_count != 2'd2) begin
                            r_count <= r_count + 2'd1;
                        end
                    end
                end else begin
                    r_pos   <= n_pos;
                    r_match <= n_match;
                    r_ended <= r_ended | is_nl;
                end
            end

            // scan sequencing
            if (i_cmd.rd_start) begin
                r_scan_word <= {1'b0, r_ptr[7:6]};
                r_scan_lo   <= r_ptr[5:0];
            end else if (i_cmd.restart_zero) begin
                r_scan_word <= '0;
                r_scan_lo   <= '0;
            end else if (i_cmd.next_start) begin
                {r_scan_word, r_scan_lo} <= succ_start;
            end else if (i_cmd.next_latch) begin
                r_nxt_hit <= scan_hit;
            end else if (i_cmd.scan_step) begin
                r_scan_word <= r_scan_word + 3'd1;
                r_scan_lo   <= '0;
            end

            if (i_cmd.emit) begin
                r_ptr       <= n_ptr;
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    // ---- payload registers ----
    always_ff @(posedge i_clk) begin
        if (i_cmd.next_start) begin
            r_found <= hit_pos;
        end
        if (i_cmd.next_latch) begin
            r_nxt <= hit_pos;
        end
        if (i_cmd.emit) begin
            o_verdict <= n_verdict;
            o_char    <= n_char;
            o_last    <= n_last;
        end
    end

    // store: one write, one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (store_we) begin
            r_store[r_pos[ADDR_W-1:0]] <= byte_c;
        end
        r_rdata <= r_store[r_ptr[ADDR_W-1:0]];
    end

endmodule

// ===== hdl/prefix_filter_next_char_set_core.sv =====
// channel     | direction | tdata             | tuser          | tlast
// ------------+-----------+-------------------+----------------+-----------
// s_axis      | in        | [7:0] char_byte   | [0] opcode     | line_end
// m_axis      | out       | [7:0] char_out    | [1:0] verdict  | last_item
// cfg write   | in        | i_cfg_data[63:0], index i_cfg_index[1:0], strobe i_cfg_we
//
// a line byte transfer leaves the block idle; the next item is taken in the following cycle
// a single-match or not-found report read goes from idle to the emit step (the store read is registered)
// a next-character report read walks the find, next and emit steps; find and next run the character set
//   scan, which examines one 64-bit word of the 256-bit set per cycle
// reset is synchronous, active low; the line store needs no clearing pass
// input is taken while a result waits in the output register; a report read
//   holds in its last step until the output register is free
module prefix_filter_next_char_set_core import pfn_pkg::*; #(
    parameter int MAX_PREFIX = MAX_PREFIX_DEF,
    parameter int MAX_LINE   = MAX_LINE_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // configuration writes
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,

    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_byte
    input  logic [0:0]  s_axis_tuser,   // [0] opcode
    input  logic        s_axis_tlast,   // line_end

    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] char_out
    output logic [1:0]  m_axis_tuser,   // [1:0] verdict
    output logic        m_axis_tlast    // last_item
);

    // command and status between sequencer and datapath
    t_cmd  cmd;
    t_stat stat;

    // sequencer: line bytes taken straight from idle, next-character report reads walk through set scan
    pfn_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_opcode   (s_axis_tuser[0]),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // datapath: prefix compare, next-character set, first line store, output register
    pfn_dpath #(
        .MAX_PREFIX (MAX_PREFIX),
        .MAX_LINE   (MAX_LINE)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_char      (s_axis_tdata),
        .i_line_end  (s_axis_tlast),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_verdict   (m_axis_tuser),
        .o_char      (m_axis_tdata),
        .o_last      (m_axis_tlast)
    );

endmodule

// ===== hdl/pfn_checker.sv =====
module pfn_checker import pfn_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_cfg_we,
    input logic [1:0]  i_cfg_index,
    input logic [63:0] i_cfg_data,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [7:0]  s_axis_tdata,
    input logic [0:0]  s_axis_tuser,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata,
    input logic [1:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    // no result pending right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("stalled result changed");

    // not found is a single zero item
    a_none_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == VERDICT_NONE |->
            m_axis_tdata == 8'd0 && m_axis_tlast)
        else $error("not-found result malformed");

    // a report read drops input ready until the block is back in idle
    a_report_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser[0] == OP_REPORT |=> !s_axis_tready)
        else $error("report read did not hold input");

    // a line byte never raises a result
    a_byte_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser[0] == OP_LINE_BYTE
            && !m_axis_tvalid |=> !m_axis_tvalid)
        else $error("line byte produced a result");

endmodule

bind prefix_filter_next_char_set_core pfn_checker u_pfn_checker (.*);

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import pfn_pkg::*;

    // line store depth as the block sizes it, prefix bytes in use at most
    localparam int STORE_DEPTH    = (MAX_LINE_DEF < 255) ? MAX_LINE_DEF : 255;
    localparam int PREFIX_MAX     = MAX_PREFIX_DEF;
    // stimulus volume, quiet tail, settle time and watchdog
    localparam int ITEM_TARGET    = 1250;
    localparam int CALM_ITEMS     = 150;
    localparam int SETTLE_CYCLES  = 20;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef logic [7:0] t_byte_queue[$];

    // one report transfer as the block should produce it
    typedef struct packed {
        logic [1:0] verdict;
        logic [7:0] char_out;
        logic       last_item;
    } t_report_item;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic [1:0]  i_cfg_index   = CFG_PREFIX_LOW;
    logic [63:0] i_cfg_data    = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;   // [7:0] char_byte
    logic [0:0]  s_axis_tuser  = OP_LINE_BYTE;   // [0] opcode
    logic        s_axis_tlast  = 1'b0;   // line_end
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;   // [7:0] char_out
    logic [1:0]  m_axis_tuser;   // [1:0] verdict
    logic        m_axis_tlast;   // last_item

    prefix_filter_next_char_set_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #4 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // key filter predictor: own copy of configuration and line state
    // ------------------------------------------------------------------
    logic [63:0]  pf_low   = '0;
    logic [63:0]  pf_high  = '0;
    logic [4:0]   pf_len   = '0;
    logic [7:0]   cur_pos  = '0;
    logic         cur_matching      = 1'b1;
    logic         cur_after_newline = 1'b0;
    logic [1:0]   hit_count = '0;       // saturates at two
    logic [255:0] follow_set = '0;      // folded bytes seen right after the prefix
    logic [7:0]   kept_line [0:STORE_DEPTH-1];
    logic [7:0]   kept_len  = '0;
    logic         keeping   = 1'b1;     // still capturing the first match
    logic [8:0]   walk_ptr  = '0;       // report position

    t_report_item pending_report_items[$];

    // run control shared by the tests
    int  items_sent  = 0;
    int  idle_pct    = 0;   // chance per item of a sender gap
    int  stall_pct   = 0;   // chance per cycle of a receiver stall
    int  stall_left  = 0;
    int  error_count = 0;
    int  quiet_cycles = 0;
    t_report_item got_item;
    t_report_item want_item;

    function automatic logic [7:0] ascii_lower(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
    endfunction

    function automatic logic [7:0] ascii_upper(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) ? c - 8'h20 : c;
    endfunction

    function automatic int active_prefix_len();
        return (pf_len > PREFIX_MAX) ? PREFIX_MAX : int'(pf_len);
    endfunction

    function automatic logic [7:0] prefix_char(input int i);
        logic [63:0] w;
        w = (i < 8) ? pf_low : pf_high;
        return ascii_lower(w[8 * (i % 8) +: 8]);
    endfunction

    // advance the filter by one accepted transfer; report reads queue a result
    function automatic void advance_key_filter(input logic op, input logic [7:0] raw,
                                               input logic ends);
        int plen;
        int pos;
        int found;
        int succ;
        int k;
        logic [7:0] c;
        t_report_item item;
        plen = active_prefix_len();
        if (op == OP_LINE_BYTE) begin
            walk_ptr = '0;
            if (!cur_after_newline) begin
                if (raw == NEWLINE_BYTE) begin
                    // rest of this line is ignored until its end marker
                    cur_after_newline = 1'b1;
                end else begin
                    c = ascii_lower(raw);
                    pos = cur_pos;
                    if (pos < plen) begin
                        if (c != prefix_char(pos))
                            cur_matching = 1'b0;
                    end else if (pos == plen && cur_matching) begin
                        follow_set[c] = 1'b1;
                    end
                    if (keeping && pos < STORE_DEPTH)
                        kept_line[pos] = c;
                    if (pos < 255)
                        cur_pos = 8'(pos + 1);
                end
            end
            if (ends) begin
                if (cur_matching && cur_pos >= plen) begin
                    if (hit_count == 0 && keeping) begin
                        pos = cur_pos;
                        kept_len = 8'((pos < STORE_DEPTH) ? pos : STORE_DEPTH);
                        keeping = 1'b0;
                    end
                    if (hit_count < 2)
                        hit_count = hit_count + 2'd1;
                end
                cur_pos = '0;
                cur_matching = 1'b1;
                cur_after_newline = 1'b0;
            end
        end else begin
            item.verdict = VERDICT_NONE;
            item.char_out = '0;
            item.last_item = 1'b1;
            if (hit_count == 1) begin
                // walk the kept line, an empty line gives a single zero byte
                item.verdict = VERDICT_SINGLE;
                if (kept_len != 0) begin
                    if (walk_ptr >= kept_len)
                        walk_ptr = '0;
                    item.char_out = ascii_upper(kept_line[walk_ptr]);
                    item.last_item = (walk_ptr + 1 >= kept_len);
                    walk_ptr = item.last_item ? 9'd0 : walk_ptr + 9'd1;
                end else begin
                    walk_ptr = '0;
                end
            end else if (hit_count >= 2 && follow_set != '0) begin
                // next set member at or after the pointer, wrapping to the lowest
                found = 256;
                succ = 256;
                for (k = 0; k < 256; k++)
                    if (found == 256 && k >= walk_ptr && follow_set[k])
                        found = k;
                for (k = 0; k < 256; k++)
                    if (found == 256 && follow_set[k])
                        found = k;
                for (k = 0; k < 256; k++)
                    if (succ == 256 && k > found && follow_set[k])
                        succ = k;
                item.verdict = VERDICT_SET;
                item.char_out = ascii_upper(found[7:0]);
                item.last_item = (succ == 256);
                walk_ptr = (succ == 256) ? 9'd0 : succ[8:0];
            end else begin
                walk_ptr = '0;
            end
            pending_report_items.push_back(item);
        end
    endfunction

    function automatic void note_error(input string msg);
        error_count++;
        if (error_count <= 10)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endfunction

    // ------------------------------------------------------------------
    // result side: random stall bursts, field compare against oldest expectation
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_axis_tready <= (stall_left == 1);
        end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
            stall_left <= $urandom_range(1, 13);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_item = {m_axis_tuser, m_axis_tdata, m_axis_tlast};
            if (pending_report_items.size() == 0) begin
                note_error($sformatf("report transfer with none pending: %s%0d %s%02h %s%0b",
                                     "verdict ", got_item.verdict,
                                     "char ", got_item.char_out,
                                     "last ", got_item.last_item));
            end else begin
                want_item = pending_report_items.pop_front();
                if (got_item.verdict !== want_item.verdict)
                    note_error($sformatf("verdict expected %0d got %0d",
                                         want_item.verdict, got_item.verdict));
                if (got_item.char_out !== want_item.char_out)
                    note_error($sformatf("char_out expected %02h got %02h",
                                         want_item.char_out, got_item.char_out));
                if (got_item.last_item !== want_item.last_item)
                    note_error($sformatf("last_item expected %0b got %0b (char %02h)",
                                         want_item.last_item, got_item.last_item,
                                         want_item.char_out));
            end
        end
    end

    // watchdog: cycles with no transfer on either stream
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("testbench: done, errors");
        $finish;
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // one input transfer, with an optional sender gap in front of it
    task automatic send_item(input logic op, input logic [7:0] ch, input logic ends);
        int gap;
        gap = 0;
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
            gap = $urandom_range(1, 13);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= ch;
        s_axis_tuser <= op;
        s_axis_tlast <= ends;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        advance_key_filter(op, ch, ends);
        items_sent++;
    endtask

    task automatic send_line(input t_byte_queue bytes);
        int i;
        for (i = 0; i < bytes.size(); i++)
            send_item(OP_LINE_BYTE, bytes[i], i == bytes.size() - 1);
    endtask

    task automatic send_text(input string s);
        t_byte_queue bytes;
        int i;
        for (i = 0; i < s.len(); i++)
            bytes.push_back(s[i]);
        send_line(bytes);
    endtask

    // report reads carry junk in char_byte and line_end, both ignored there
    task automatic send_reads(input int n);
        int i;
        for (i = 0; i < n; i++)
            send_item(OP_REPORT, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endtask

    // sender holds off until every report transfer is back and the block is quiet
    task automatic wait_for_reports();
        s_axis_tvalid <= 1'b0;
        while (pending_report_items.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // all three registers, written back to back while idle
    task automatic load_prefix(input logic [127:0] bytes, input logic [4:0] len);
        wait_for_reports();
        i_cfg_we <= 1'b1;
        i_cfg_index <= CFG_PREFIX_LOW;
        i_cfg_data <= bytes[63:0];
        @(posedge i_clk);
        pf_low = bytes[63:0];
        i_cfg_index <= CFG_PREFIX_HIGH;
        i_cfg_data <= bytes[127:64];
        @(posedge i_clk);
        pf_high = bytes[127:64];
        i_cfg_index <= CFG_PREFIX_LEN;
        i_cfg_data <= {59'd0, len};
        @(posedge i_clk);
        pf_len = len;
        i_cfg_we <= 1'b0;
    endtask

    // text in the low bytes, random junk in the unused ones
    function automatic logic [127:0] pack_text(input string s);
        logic [127:0] v;
        int i;
        v = {$urandom, $urandom, $urandom, $urandom};
        for (i = 0; i < s.len() && i < 16; i++)
            v[8 * i +: 8] = s[i];
        return v;
    endfunction

    function automatic logic [7:0] rand_letter();
        logic [7:0] c;
        c = 8'h61 + 8'($urandom_range(0, 25));
        return $urandom_range(0, 1) ? c - 8'h20 : c;
    endfunction

    // line that carries the current prefix in random case, then a random tail;
    // with damage allowed a prefix byte may be wrong or a newline may land anywhere
    task automatic send_prefixed_line(input int tail_len, input bit damage);
        t_byte_queue bytes;
        int plen;
        int i;
        logic [7:0] c;
        plen = active_prefix_len();
        for (i = 0; i < plen; i++) begin
            c = prefix_char(i);
            if (c >= 8'h61 && c <= 8'h7A && $urandom_range(0, 1))
                c = c - 8'h20;
            bytes.push_back(c);
        end
        if (damage && plen != 0 && $urandom_range(0, 9) == 0)
            bytes[$urandom_range(0, plen - 1)] = 8'($urandom_range(0, 255));
        for (i = 0; i < tail_len; i++) begin
            c = $urandom_range(0, 1) ? rand_letter() : 8'($urandom_range(0, 255));
            if (!damage && c == NEWLINE_BYTE)
                c = 8'h6E;
            bytes.push_back(c);
        end
        if (bytes.size() == 0)
            bytes.push_back(8'($urandom_range(0, 255)));
        if (damage && $urandom_range(0, 9) == 0)
            bytes[$urandom_range(0, bytes.size() - 1)] = NEWLINE_BYTE;
        send_line(bytes);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset prefix length is zero: an empty line matches once, a second
    // empty line matches again with nothing in the next-character set
    task automatic test_empty_line_match();
        send_reads(1);
        send_text("\n");
        send_reads(2);
        send_text("\nx");
        send_reads(2);
    endtask

    // case-blind compare, short lines, newline cut, line ending at the prefix
    task automatic test_prefix_compare();
        load_prefix(pack_text("aB"), 5'd2);
        send_text("xb");
        send_text("aX");
        send_text("a");
        send_text("a\nBc");
        send_text("AB");
        send_reads(1);
        send_text("AbQ");
        send_reads(1);
    endtask

    // set walk in ascending order with wrap, and a line byte restarting the walk
    task automatic test_report_walk();
        t_byte_queue bytes;
        send_text("aBz");
        send_text("ab~");
        bytes = '{8'h41, 8'h62, 8'hFF};
        send_line(bytes);
        send_text("ab\nm");
        send_reads(6);
        send_text("zz");
        send_reads(2);
    endtask

    // prefix lengths over the maximum clamp to sixteen; all-zero prefix bytes
    task automatic test_long_prefix();
        t_byte_queue bytes;
        int i;
        load_prefix(pack_text("AbCdEfGhIjKlMnOp"), 5'd31);
        send_text("aBcDeFgHiJkLmNoPr");
        send_text("abcdefghijklmnoXs");
        send_reads(3);
        load_prefix(pack_text("AbCdEfGhIjKlMnOp"), 5'd16);
        send_text("abcdefghijklmnop@");
        load_prefix('0, 5'd16);
        for (i = 0; i < 16; i++)
            bytes.push_back(8'h00);
        bytes.push_back(8'h78);
        send_line(bytes);
        send_reads(4);
    endtask

    // lines past the store depth and past the position counter range
    task automatic test_long_lines();
        load_prefix({128{1'b1}}, 5'd0);
        send_prefixed_line(300, 1'b0);
        send_reads($countones(follow_set) + 1);
        load_prefix(pack_text("kE"), 5'd2);
        send_prefixed_line(268, 1'b0);
        send_reads(3);
    endtask

    // bulk traffic: mostly well-formed prefixed lines, some noise and read runs
    task automatic test_random_traffic();
        int next_shift;
        int pick;
        int n;
        int i;
        logic [127:0] bytes;
        logic [4:0] len;
        t_byte_queue noise;
        next_shift = items_sent;
        while (items_sent < ITEM_TARGET) begin
            if (items_sent >= ITEM_TARGET - CALM_ITEMS) begin
                idle_pct = 0;
                stall_pct = 0;
            end else if (items_sent >= next_shift) begin
                pick = $urandom_range(0, 2);
                idle_pct = (pick == 0) ? 0 : (pick == 1) ? 10 : 35;
                pick = $urandom_range(0, 2);
                stall_pct = (pick == 0) ? 0 : (pick == 1) ? 3 : 12;
                next_shift = items_sent + 100;
            end
            pick = $urandom_range(0, 39);
            if (pick == 0) begin
                // new prefix, mostly short, sometimes the longest or clamped
                bytes = {$urandom, $urandom, $urandom, $urandom};
                for (i = 0; i < 16; i++)
                    if ($urandom_range(0, 4) != 0)
                        bytes[8 * i +: 8] = rand_letter();
                n = $urandom_range(0, 9);
                len = (n == 0) ? 5'd0 : (n == 1) ? 5'd16 :
                      (n == 2) ? 5'($urandom_range(17, 31)) : 5'($urandom_range(1, 4));
                load_prefix(bytes, len);
            end else if (pick < 9) begin
                if ($urandom_range(0, 3) == 0) begin
                    n = (hit_count == 1) ? kept_len + 2 : $countones(follow_set) + 2;
                    if (n > 70)
                        n = 70;
                end else begin
                    n = $urandom_range(1, 6);
                end
                send_reads(n);
            end else if (pick < 13) begin
                noise = {};
                n = $urandom_range(1, 8);
                for (i = 0; i < n; i++)
                    noise.push_back(($urandom_range(0, 7) == 0) ? NEWLINE_BYTE :
                                    8'($urandom_range(0, 255)));
                send_line(noise);
            end else begin
                send_prefixed_line($urandom_range(0, 4), 1'b1);
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_line_match();
        test_prefix_compare();
        test_report_walk();
        test_long_prefix();
        test_long_lines();
        test_random_traffic();

        // drain everything still in flight, then let the block settle
        wait_for_reports();
        if (error_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
